>>> hw/rtl/gsa_pkg.sv
package gsa_pkg;

    // Default sizing
    localparam int SLOT_COUNT_DEF = 256;
    localparam int GEN_BITS_DEF   = 16;

    // Field widths of the stream items
    localparam int OP_W     = 2;
    localparam int HIDX_W   = 8;
    localparam int HGEN_W   = 16;
    localparam int MODEL_W  = 16;
    localparam int STATUS_W = 2;

    // Packed positions, lowest field first, padded to whole bytes
    localparam int IN_OP_LSB    = 0;
    localparam int IN_HIDX_LSB  = IN_OP_LSB + OP_W;
    localparam int IN_HGEN_LSB  = IN_HIDX_LSB + HIDX_W;
    localparam int IN_TAG_LSB   = IN_HGEN_LSB + HGEN_W;
    localparam int IN_USED_W    = IN_TAG_LSB + MODEL_W;
    localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

    localparam int OUT_ST_LSB   = 0;
    localparam int OUT_IDX_LSB  = OUT_ST_LSB + STATUS_W;
    localparam int OUT_GEN_LSB  = OUT_IDX_LSB + HIDX_W;
    localparam int OUT_MOD_LSB  = OUT_GEN_LSB + HGEN_W;
    localparam int OUT_USED_W   = OUT_MOD_LSB + MODEL_W;
    localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
    localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd2;

endpackage

>>> hw/rtl/generational_slot_allocator.sv
// Generational slot allocator: a table of SLOT_COUNT handle slots, each holding an alive
// flag, a GEN_BITS generation and a 16-bit model tag, kept in a single-port-read slot RAM,
// with a second RAM as a LIFO stack of freed slots. Create reuses the most recently freed
// slot (generation plus one, wrapping) or else the next never-used slot (generation 1);
// destroy and lookup check the handle against the table. One input transfer yields exactly
// one result transfer. The result is registered in S_EXEC, which follows acceptance directly, or
// follows S_POP for a create that reuses a freed slot, because the stack read and the slot read
// are then chained through the registered reads of the two RAMs; s_tready returns in the cycle
// after the result is registered, so a new item is taken only once the last one is done. A
// result waiting on m_tready holds the block only when the following result is ready to be
// written. No clearing pass is needed after reset: slots at or above the fill count are
// never read as live.
module generational_slot_allocator #(
    parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF,
    parameter int GEN_BITS   = gsa_pkg::GEN_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // op[1:0], handle_index[9:2], handle_generation[25:10], model_tag[41:26]
    input  logic [gsa_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[1:0], out_index[9:2], out_generation[25:10], out_model[41:26]
    output logic [gsa_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    import gsa_pkg::*;

    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int CNT_W  = IDX_W + 1;
    localparam int IX_W   = (IDX_W > HIDX_W) ? IDX_W : HIDX_W;
    localparam int UC_W   = (CNT_W > HIDX_W) ? CNT_W : HIDX_W;
    localparam int CMP_W  = (GEN_BITS > HGEN_W) ? GEN_BITS : HGEN_W;
    localparam int SLOT_W = 1 + GEN_BITS + MODEL_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    // Control state
    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] used_count_reg, used_count_next;
    logic [CNT_W-1:0] free_count_reg, free_count_next;
    logic             from_free_reg, from_free_next;
    logic             m_valid_reg, m_valid_next;

    // Latched request
    logic [OP_W-1:0]    op_reg;
    logic [HIDX_W-1:0]  hidx_reg;
    logic [HGEN_W-1:0]  hgen_reg;
    logic [MODEL_W-1:0] tag_reg;
    logic [IDX_W-1:0]   pop_idx_reg;

    // Result register
    logic [STATUS_W-1:0] status_reg;
    logic [HIDX_W-1:0]   out_index_reg;
    logic [HGEN_W-1:0]   out_gen_reg;
    logic [MODEL_W-1:0]  out_model_reg;

    // RAM ports
    logic              slot_we, slot_re;
    logic [IDX_W-1:0]  slot_wa, slot_ra;
    logic [SLOT_W-1:0] slot_wd, slot_q;
    logic              stack_we, stack_re;
    logic [IDX_W-1:0]  stack_wa, stack_ra, stack_q;

    // Input field views
    logic [OP_W-1:0]    s_op;
    logic [HIDX_W-1:0]  s_hidx;
    logic [HGEN_W-1:0]  s_hgen;
    logic [MODEL_W-1:0] s_tag;
    logic [IX_W-1:0]    s_hidx_ext, hidx_ext;
    logic [CNT_W-1:0]   free_dec;

    assign s_op   = s_tdata[IN_OP_LSB +: OP_W];
    assign s_hidx = s_tdata[IN_HIDX_LSB +: HIDX_W];
    assign s_hgen = s_tdata[IN_HGEN_LSB +: HGEN_W];
    assign s_tag  = s_tdata[IN_TAG_LSB +: MODEL_W];

    assign s_hidx_ext = IX_W'(s_hidx);
    assign hidx_ext   = IX_W'(hidx_reg);
    assign free_dec   = free_count_reg - CNT_W'(1);

    logic accept, out_free, do_exec;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign do_exec  = (state_reg == S_EXEC) && out_free;

    // Slot word fields
    logic                slot_alive;
    logic [GEN_BITS-1:0] slot_gen;
    logic [MODEL_W-1:0]  slot_model;
    logic [CMP_W-1:0]    slot_gen_ext, hgen_ext;
    logic                handle_ok;

    assign slot_alive   = slot_q[SLOT_W-1];
    assign slot_gen     = slot_q[MODEL_W +: GEN_BITS];
    assign slot_model   = slot_q[MODEL_W-1:0];
    assign slot_gen_ext = CMP_W'(slot_gen);
    assign hgen_ext     = CMP_W'(hgen_reg);
    assign handle_ok    = (UC_W'(hidx_reg) < UC_W'(used_count_reg)) && slot_alive
                          && (slot_gen_ext == hgen_ext);

    // Create slot choice
    logic [IDX_W-1:0]    create_idx;
    logic [GEN_BITS-1:0] create_gen;
    logic [IX_W-1:0]     create_idx_ext;
    logic [CMP_W-1:0]    create_gen_ext;

    assign create_idx     = from_free_reg ? pop_idx_reg : used_count_reg[IDX_W-1:0];
    assign create_gen     = from_free_reg ? (slot_gen + GEN_BITS'(1)) : GEN_BITS'(1);
    assign create_idx_ext = IX_W'(create_idx);
    assign create_gen_ext = CMP_W'(create_gen);

    // Result and write-back of the executing item
    logic [STATUS_W-1:0] res_status;
    logic [HIDX_W-1:0]   res_index;
    logic [HGEN_W-1:0]   res_gen;
    logic [MODEL_W-1:0]  res_model;
    logic                wr_slot, wr_stack;

    always_comb begin
        res_status      = STAT_INVALID;
        res_index       = hidx_reg;
        res_gen         = hgen_reg;
        res_model       = '0;
        wr_slot         = 1'b0;
        wr_stack        = 1'b0;
        slot_wa         = hidx_ext[IDX_W-1:0];
        slot_wd         = {1'b0, slot_gen, slot_model};
        used_count_next = used_count_reg;
        free_count_next = free_count_reg;
        case (op_reg)
            OP_CREATE: begin
                if (from_free_reg || (used_count_reg < CNT_W'(SLOT_COUNT))) begin
                    res_status = STAT_OK;
                    res_index  = create_idx_ext[HIDX_W-1:0];
                    res_gen    = create_gen_ext[HGEN_W-1:0];
                    res_model  = tag_reg;
                    wr_slot    = 1'b1;
                    slot_wa    = create_idx;
                    slot_wd    = {1'b1, create_gen, tag_reg};
                    if (from_free_reg) begin
                        free_count_next = free_dec;
                    end else begin
                        used_count_next = used_count_reg + CNT_W'(1);
                    end
                end else begin
                    res_status = STAT_FULL;
                    res_index  = '0;
                    res_gen    = '0;
                end
            end
            OP_DESTROY: begin
                if (handle_ok) begin
                    res_status = STAT_OK;
                    wr_slot    = 1'b1;
                    if (free_count_reg < CNT_W'(SLOT_COUNT)) begin
                        wr_stack        = 1'b1;
                        free_count_next = free_count_reg + CNT_W'(1);
                    end
                end
            end
            OP_LOOKUP: begin
                if (handle_ok) begin
                    res_status = STAT_OK;
                    res_model  = slot_model;
                end
            end
            default: begin
                res_status = STAT_INVALID;
            end
        endcase
        if (!do_exec) begin
            used_count_next = used_count_reg;
            free_count_next = free_count_reg;
        end
    end

    assign slot_we  = do_exec && wr_slot;
    assign stack_we = do_exec && wr_stack;
    assign stack_wa = free_count_reg[IDX_W-1:0];

    // Read requests: handle slot and stack top on acceptance, popped slot after the pop
    assign stack_re = accept;
    assign stack_ra = free_dec[IDX_W-1:0];
    assign slot_re  = accept || (state_reg == S_POP);
    assign slot_ra  = (state_reg == S_POP) ? stack_q : s_hidx_ext[IDX_W-1:0];

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        from_free_next = from_free_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    from_free_next = (s_op == OP_CREATE) && (free_count_reg != '0);
                    state_next     = from_free_next ? S_POP : S_EXEC;
                end
            end
            S_POP: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: load on execute, drop on a completed transfer
    always_comb begin
        m_valid_next = m_valid_reg;
        if (do_exec) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            used_count_reg <= '0;
            free_count_reg <= '0;
            from_free_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_count_reg <= used_count_next;
            free_count_reg <= free_count_next;
            from_free_reg  <= from_free_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Hold the request, the popped index and the result
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_op;
            hidx_reg <= s_hidx;
            hgen_reg <= s_hgen;
            tag_reg  <= s_tag;
        end
        if (state_reg == S_POP) begin
            pop_idx_reg <= stack_q;
        end
        if (do_exec) begin
            status_reg    <= res_status;
            out_index_reg <= res_index;
            out_gen_reg   <= res_gen;
            out_model_reg <= res_model;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_model_reg, out_gen_reg, out_index_reg, status_reg});

    // Slot table: alive, generation, model tag
    gsa_ram #(
        .DEPTH (SLOT_COUNT),
        .WIDTH (SLOT_W)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_wa),
        .wdata (slot_wd),
        .re    (slot_re),
        .raddr (slot_ra),
        .rdata (slot_q)
    );

    // Free slot stack
    gsa_ram #(
        .DEPTH (SLOT_COUNT),
        .WIDTH (IDX_W)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stack_we),
        .waddr (stack_wa),
        .wdata (hidx_ext[IDX_W-1:0]),
        .re    (stack_re),
        .raddr (stack_ra),
        .rdata (stack_q)
    );

endmodule

>>> hw/rtl/gsa_ram.sv
module gsa_ram #(
    parameter int DEPTH = gsa_pkg::SLOT_COUNT_DEF,
    parameter int WIDTH = gsa_pkg::GEN_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/gsa_checker.sv
module gsa_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [gsa_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import gsa_pkg::*;

    logic [STATUS_W-1:0] m_status;
    assign m_status = m_tdata[OUT_ST_LSB +: STATUS_W];

    // A stalled result transfer holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only defined status codes leave the block
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_status == STAT_OK) || (m_status == STAT_FULL)
                     || (m_status == STAT_INVALID))
        else $error("undefined status code");

    // A full table answers with an all-zero handle and tag
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_status == STAT_FULL) |-> (m_tdata[OUT_USED_W-1:OUT_IDX_LSB] == '0))
        else $error("table full result carries data");

    // A rejected handle never returns a tag
    a_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_status == STAT_INVALID) |-> (m_tdata[OUT_MOD_LSB +: MODEL_W] == '0))
        else $error("invalid handle result carries a tag");

    // No result is offered straight after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (.*);
